[design/iap_pkg.sv]
// ----------------------------------------------------------------------------
// Identity address parser package
// Item types, character codes and parse phases shared by the parser.
// ----------------------------------------------------------------------------
package iap_pkg;

  // Default limit on the identifier length.
  localparam int MAX_LEN_DEF = 255;

  // Characters with a special meaning in an identifier.
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Printable range for base characters.
  localparam logic [7:0] CH_BASE_LO = 8'h21;
  localparam logic [7:0] CH_BASE_HI = 8'h7E;

  // Identifier kinds reported in the result.
  localparam logic [1:0] KIND_GENERIC = 2'd0;
  localparam logic [1:0] KIND_SERVICE = 2'd1;
  localparam logic [1:0] KIND_DOMAIN  = 2'd2;

  // How the localpart started.
  localparam logic [1:0] LSK_NONE    = 2'd0;
  localparam logic [1:0] LSK_GENERIC = 2'd1;
  localparam logic [1:0] LSK_SERVICE = 2'd2;

  // Parse phases of the character classifier.
  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_SERVICE  = 3'd1,
    PH_LOCAL    = 3'd2,
    PH_OPTION   = 3'd3,
    PH_NEWLABEL = 3'd4,
    PH_DOMAIN   = 3'd5
  } phase_t;

  // One input item: a character and the selector flag.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       selector_mode;
  } iap_in_t;

  // One result item, produced on the terminator.
  typedef struct packed {
    logic       valid_res;
    logic [1:0] id_kind;
    logic       has_signature;
    logic [7:0] option_count;
    logic [7:0] total_len;
    logic [7:0] local_len;
    logic [7:0] domain_len;
    logic [7:0] base_len;
    logic [7:0] first_opt_start;
    logic [7:0] first_opt_len;
    logic [7:0] sig_len;
  } iap_out_t;

endpackage

[design/identity_address_parser_top.sv]
// ----------------------------------------------------------------------------
// Identity address parser
// Classifies an identifier one character per item and reports its segments.
// ----------------------------------------------------------------------------
// The parser takes one character per clock and never stalls on ordinary
// characters: each accepted item goes into an input register, and in the next
// cycle one pass of the phase logic updates the parse state. A zero byte ends
// the string; its result is written into the output register in that same pass
// and is offered there until res_stall lets it go.
// Only a terminator that finds the output register still held by res_stall
// waits in the input register, and char_stall is raised for that time.
// Strings longer than MAX_LEN characters are reported as invalid at MAX_LEN.
module identity_address_parser_top
  import iap_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  iap_in_t  char_item,
  output logic     res_valid,
  input  logic     res_stall,
  output iap_out_t res_item
);

  // Positions and marks hold values up to MAX_LEN.
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);
  localparam logic [PW-1:0] ONE     = PW'(1);
  localparam logic [PW-1:0] TWO     = PW'(2);

  // Reduce a position to the 8-bit result width.
  function automatic logic [7:0] to8(input logic [PW-1:0] v);
    logic [PW+7:0] w;
    w = {8'd0, v};
    return w[7:0];
  endfunction

  // Input register.
  logic    s1_valid;
  iap_in_t s1_item;

  // Parse state.
  phase_t        parse_phase, parse_phase_next;
  logic [PW-1:0] char_pos, char_pos_next;
  logic          failed_flag, failed_flag_next;
  logic [PW-1:0] error_pos, error_pos_next;
  logic          selector_latch, selector_latch_next;
  logic [1:0]    local_start_kind, local_start_kind_next;
  logic [PW-1:0] base_mark, base_mark_next;
  logic [PW-1:0] first_opt_mark, first_opt_mark_next;
  logic [PW-1:0] second_opt_mark, second_opt_mark_next;
  logic [PW-1:0] cur_opt_mark, cur_opt_mark_next;
  logic [PW-1:0] prev_opt_mark, prev_opt_mark_next;
  logic [PW-1:0] at_mark, at_mark_next;
  logic [PW-1:0] opt_counter, opt_counter_next;

  logic     term;
  logic     sel;
  logic     out_free;
  logic     s1_go;
  iap_out_t result;

  // Handshake: only a terminator can be held back by a full output register.
  assign term       = (s1_item.char_byte == CH_NUL);
  assign out_free   = !res_valid || !res_stall;
  assign char_stall = s1_valid && term && !out_free;
  assign s1_go      = s1_valid && !char_stall;

  // The selector flag is taken from the first character of a string.
  assign sel = (char_pos == '0) ? s1_item.selector_mode : selector_latch;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      s1_item <= char_item;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_START;
      char_pos         <= '0;
      failed_flag      <= 1'b0;
      error_pos        <= '0;
      selector_latch   <= 1'b0;
      local_start_kind <= LSK_NONE;
      base_mark        <= '0;
      first_opt_mark   <= '0;
      second_opt_mark  <= '0;
      cur_opt_mark     <= '0;
      prev_opt_mark    <= '0;
      at_mark          <= '0;
      opt_counter      <= '0;
    end else if (s1_go) begin
      parse_phase      <= parse_phase_next;
      char_pos         <= char_pos_next;
      failed_flag      <= failed_flag_next;
      error_pos        <= error_pos_next;
      selector_latch   <= selector_latch_next;
      local_start_kind <= local_start_kind_next;
      base_mark        <= base_mark_next;
      first_opt_mark   <= first_opt_mark_next;
      second_opt_mark  <= second_opt_mark_next;
      cur_opt_mark     <= cur_opt_mark_next;
      prev_opt_mark    <= prev_opt_mark_next;
      at_mark          <= at_mark_next;
      opt_counter      <= opt_counter_next;
    end
  end

  // Character classification and phase transitions.
  always_comb begin
    logic          b;
    logic          ok;
    logic [PW-1:0] mark;
    logic [7:0]    c;

    c    = s1_item.char_byte;
    b    = (c inside {[CH_BASE_LO:CH_BASE_HI]}) && (c != CH_PLUS) &&
           (c != CH_DOT) && (c != CH_AT);
    mark = char_pos + ONE;
    ok   = 1'b1;

    parse_phase_next      = parse_phase;
    char_pos_next         = char_pos;
    failed_flag_next      = failed_flag;
    error_pos_next        = error_pos;
    selector_latch_next   = sel;
    local_start_kind_next = local_start_kind;
    base_mark_next        = base_mark;
    first_opt_mark_next   = first_opt_mark;
    second_opt_mark_next  = second_opt_mark;
    cur_opt_mark_next     = cur_opt_mark;
    prev_opt_mark_next    = prev_opt_mark;
    at_mark_next          = at_mark;
    opt_counter_next      = opt_counter;

    if (term) begin
      // The terminator returns every field to its reset value.
      parse_phase_next      = PH_START;
      char_pos_next         = '0;
      failed_flag_next      = 1'b0;
      error_pos_next        = '0;
      selector_latch_next   = 1'b0;
      local_start_kind_next = LSK_NONE;
      base_mark_next        = '0;
      first_opt_mark_next   = '0;
      second_opt_mark_next  = '0;
      cur_opt_mark_next     = '0;
      prev_opt_mark_next    = '0;
      at_mark_next          = '0;
      opt_counter_next      = '0;
    end else begin
      if (!failed_flag) begin
        if (char_pos >= MAX_POS) begin
          failed_flag_next = 1'b1;
          error_pos_next   = MAX_POS;
        end else begin
          case (parse_phase)
            PH_START: begin
              if (b || c == CH_DOT) begin
                local_start_kind_next = LSK_GENERIC;
                base_mark_next        = mark;
                parse_phase_next      = PH_LOCAL;
              end else if (c == CH_PLUS) begin
                local_start_kind_next = LSK_SERVICE;
                parse_phase_next      = PH_SERVICE;
              end else if (c == CH_AT) begin
                at_mark_next     = mark;
                parse_phase_next = PH_NEWLABEL;
              end else begin
                ok = 1'b0;
              end
            end
            PH_SERVICE: begin
              if (b || c == CH_DOT) begin
                base_mark_next   = mark;
                parse_phase_next = PH_LOCAL;
              end else if (sel && c == CH_AT) begin
                at_mark_next     = mark;
                parse_phase_next = PH_NEWLABEL;
              end else if (sel && c == CH_PLUS) begin
                cur_opt_mark_next   = mark;
                first_opt_mark_next = mark;
                opt_counter_next    = opt_counter + ONE;
                parse_phase_next    = PH_OPTION;
              end else begin
                ok = 1'b0;
              end
            end
            PH_LOCAL, PH_OPTION: begin
              if (b || c == CH_DOT) begin
                parse_phase_next = PH_LOCAL;
              end else if (c == CH_PLUS) begin
                prev_opt_mark_next = cur_opt_mark;
                cur_opt_mark_next  = mark;
                if (first_opt_mark == '0) begin
                  first_opt_mark_next = mark;
                end else if (second_opt_mark == '0) begin
                  second_opt_mark_next = mark;
                end
                opt_counter_next = opt_counter + ONE;
                parse_phase_next = PH_OPTION;
              end else if (c == CH_AT) begin
                at_mark_next     = mark;
                parse_phase_next = PH_NEWLABEL;
              end else begin
                ok = 1'b0;
              end
            end
            PH_DOMAIN: begin
              if (c == CH_DOT) begin
                parse_phase_next = PH_NEWLABEL;
              end else if (!b) begin
                ok = 1'b0;
              end
            end
            PH_NEWLABEL: begin
              if (b) begin
                parse_phase_next = PH_DOMAIN;
              end else if (!(sel && c == CH_DOT)) begin
                ok = 1'b0;
              end
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (!ok) begin
            failed_flag_next = 1'b1;
            error_pos_next   = char_pos;
          end
        end
      end
      if (char_pos < MAX_POS) begin
        char_pos_next = char_pos + ONE;
      end
    end
  end

  // Segment lengths and offsets from the marks, used on the terminator.
  always_comb begin
    logic          fin;
    logic          sig;
    logic [PW-1:0] at;
    logic [PW-1:0] sigpos;
    logic [PW-1:0] siglen;
    logic [PW-1:0] cnt;
    logic [PW-1:0] first;
    logic [PW-1:0] fp;
    logic [PW-1:0] bp;
    logic [PW-1:0] flen;
    logic [PW-1:0] blen;

    fin    = (parse_phase == PH_DOMAIN) || (sel && parse_phase == PH_NEWLABEL);
    at     = at_mark - ONE;
    sig    = (cur_opt_mark != '0) && (prev_opt_mark != '0) && (cur_opt_mark == at);
    sigpos = prev_opt_mark - ONE;
    siglen = sig ? (cur_opt_mark - prev_opt_mark) : '0;
    cnt    = sig ? (opt_counter - TWO) : opt_counter;
    first  = (sig && cnt == '0) ? '0 : first_opt_mark;
    fp     = first - ONE;
    bp     = base_mark - ONE;

    if (first == '0) begin
      flen = '0;
    end else if (second_opt_mark != '0) begin
      flen = second_opt_mark - first;
    end else if (sig) begin
      flen = sigpos - fp;
    end else begin
      flen = at - fp;
    end

    if (base_mark == '0) begin
      blen = '0;
    end else if (flen != '0) begin
      blen = fp - bp;
    end else if (sig) begin
      blen = sigpos - bp;
    end else begin
      blen = at - bp;
    end

    result = '0;
    if (failed_flag) begin
      result.total_len = to8(error_pos);
    end else if (!fin || at_mark == '0) begin
      result.total_len = to8(char_pos);
    end else begin
      result.valid_res       = 1'b1;
      case (local_start_kind)
        LSK_NONE:    result.id_kind = KIND_DOMAIN;
        LSK_SERVICE: result.id_kind = KIND_SERVICE;
        default:     result.id_kind = KIND_GENERIC;
      endcase
      result.has_signature   = sig;
      result.option_count    = to8(cnt);
      result.total_len       = to8(char_pos);
      result.local_len       = to8(at);
      result.domain_len      = to8(char_pos - at);
      result.base_len        = to8(blen);
      result.first_opt_start = (first != '0 && flen != '0) ? to8(fp) : 8'd0;
      result.first_opt_len   = to8(flen);
      result.sig_len         = to8(siglen);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && term) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && term) begin
      res_item <= result;
    end
  end

  // A new result only follows a terminator leaving the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_go && term))
    else $error("result raised without a terminator");

  // An invalid result carries only a length: the error index or the string length.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.valid_res |->
      res_item.option_count == 8'd0 && res_item.local_len == 8'd0 &&
      res_item.domain_len == 8'd0 && res_item.id_kind == KIND_GENERIC &&
      !res_item.has_signature && res_item.sig_len == 8'd0)
    else $error("invalid result with nonzero fields");

  // A failed string stays failed until its terminator.
  assert property (@(posedge clk) disable iff (rst)
    failed_flag && !(s1_go && term) |=> failed_flag)
    else $error("failure cleared before the terminator");

  // The position counter saturates at the length limit.
  assert property (@(posedge clk) disable iff (rst)
    char_pos <= MAX_POS)
    else $error("position beyond the length limit");

endmodule

[tb/tb_identity_address_parser_top.sv]
// ----------------------------------------------------------------------------
// Identity address parser testbench
// Feeds identifier strings one character per item, predicts the segment
// report for every terminator and compares each result field by field.
// Stimulus runs under several sender and receiver idle patterns, including a
// long receiver hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module tb_identity_address_parser_top;
  import iap_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 60;
  localparam int PRINT_LIMIT  = 30;

  // Predicts the parser's report and keeps the expected results in order.
  class iap_scoreboard;
    phase_t      parse_ph;
    int unsigned pos;
    bit          failed;
    int unsigned err_pos;
    bit          sel_latch;
    logic [1:0]  start_kind;
    int unsigned base_mk, first_mk, second_mk, cur_mk, prev_mk, at_mk, opt_cnt;
    iap_out_t    expected_q[$];
    int          errors;
    int          n_results, n_valid, n_sig, n_service, n_domain;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      parse_ph   = PH_START;
      pos        = 0;
      failed     = 0;
      err_pos    = 0;
      sel_latch  = 0;
      start_kind = LSK_NONE;
      base_mk    = 0;
      first_mk   = 0;
      second_mk  = 0;
      cur_mk     = 0;
      prev_mk    = 0;
      at_mk      = 0;
      opt_cnt    = 0;
    endfunction

    function bit is_base(logic [7:0] c);
      return c >= CH_BASE_LO && c <= CH_BASE_HI &&
             c != CH_PLUS && c != CH_DOT && c != CH_AT;
    endfunction

    // One transition of the character classifier; 0 means the byte is rejected.
    function bit step_phase(logic [7:0] c, bit sel, int unsigned mk);
      bit b;
      b = is_base(c);
      case (parse_ph)
        PH_START: begin
          if (b || c == CH_DOT) begin
            start_kind = LSK_GENERIC; base_mk = mk; parse_ph = PH_LOCAL;
          end else if (c == CH_PLUS) begin
            start_kind = LSK_SERVICE; parse_ph = PH_SERVICE;
          end else if (c == CH_AT) begin
            at_mk = mk; parse_ph = PH_NEWLABEL;
          end else return 0;
        end
        PH_SERVICE: begin
          if (b || c == CH_DOT) begin
            base_mk = mk; parse_ph = PH_LOCAL;
          end else if (sel && c == CH_AT) begin
            at_mk = mk; parse_ph = PH_NEWLABEL;
          end else if (sel && c == CH_PLUS) begin
            cur_mk = mk; first_mk = mk; opt_cnt++; parse_ph = PH_OPTION;
          end else return 0;
        end
        PH_LOCAL, PH_OPTION: begin
          if (b || c == CH_DOT) begin
            parse_ph = PH_LOCAL;
          end else if (c == CH_PLUS) begin
            prev_mk = cur_mk;
            cur_mk  = mk;
            if (first_mk == 0) first_mk = mk;
            else if (second_mk == 0) second_mk = mk;
            opt_cnt++;
            parse_ph = PH_OPTION;
          end else if (c == CH_AT) begin
            at_mk = mk; parse_ph = PH_NEWLABEL;
          end else return 0;
        end
        PH_DOMAIN: begin
          if (c == CH_DOT) parse_ph = PH_NEWLABEL;
          else if (!b) return 0;
        end
        PH_NEWLABEL: begin
          if (b) parse_ph = PH_DOMAIN;
          else if (!(sel && c == CH_DOT)) return 0;
        end
        default: return 0;
      endcase
      return 1;
    endfunction

    // Builds the report for the string that a terminator has just closed.
    function iap_out_t string_report(bit sel);
      iap_out_t    r;
      int unsigned at, cnt, first, siglen, sigpos, flen, blen, bp;
      bit          sig, fin;
      r      = '0;
      siglen = 0;
      sigpos = 0;
      flen   = 0;
      blen   = 0;
      sig    = 0;
      fin    = (parse_ph == PH_DOMAIN) || (sel && parse_ph == PH_NEWLABEL);
      if (failed) begin
        r.total_len = 8'(err_pos);
      end else if (!fin || at_mk == 0) begin
        r.total_len = 8'(pos);
      end else begin
        at    = at_mk - 1;
        cnt   = opt_cnt;
        first = first_mk;
        // A plus right before the at sign with an earlier plus closes the
        // signature flags; those two pluses are not options.
        if (cur_mk != 0 && prev_mk != 0 && cur_mk == at) begin
          sig    = 1;
          sigpos = prev_mk - 1;
          siglen = cur_mk - prev_mk;
          cnt    = cnt - 2;
          if (cnt == 0) first = 0;
        end
        if (first != 0) begin
          if (second_mk != 0) flen = second_mk - first;
          else if (siglen != 0) flen = sigpos - (first - 1);
          else flen = at - (first - 1);
        end
        if (base_mk != 0) begin
          bp = base_mk - 1;
          if (flen != 0) blen = (first - 1) - bp;
          else if (siglen != 0) blen = sigpos - bp;
          else blen = at - bp;
        end
        r.valid_res       = 1'b1;
        r.id_kind         = (start_kind == LSK_NONE) ? KIND_DOMAIN :
                            (start_kind == LSK_SERVICE) ? KIND_SERVICE : KIND_GENERIC;
        r.has_signature   = sig;
        r.option_count    = 8'(cnt);
        r.total_len       = 8'(pos);
        r.local_len       = 8'(at);
        r.domain_len      = 8'(pos - at);
        r.base_len        = 8'(blen);
        r.first_opt_start = (first != 0 && flen != 0) ? 8'(first - 1) : 8'd0;
        r.first_opt_len   = 8'(flen);
        r.sig_len         = 8'(siglen);
      end
      return r;
    endfunction

    // Accepted character item: advance the parse, or queue a report on a zero.
    function void note_char(iap_in_t it);
      bit sel;
      if (pos == 0) sel_latch = it.selector_mode;
      sel = sel_latch;
      if (it.char_byte == CH_NUL) begin
        expected_q.push_back(string_report(sel));
        clear_parse();
        return;
      end
      if (!failed) begin
        if (pos >= MAX_LEN_DEF) begin
          failed  = 1;
          err_pos = MAX_LEN_DEF;
        end else if (!step_phase(it.char_byte, sel, pos + 1)) begin
          failed  = 1;
          err_pos = pos;
        end
      end
      if (pos < MAX_LEN_DEF) pos++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0d expected %0d", n_results, name, got, want));
    endtask

    // Accepted result item: compare with the oldest expected report.
    task check_result(iap_out_t got);
      iap_out_t want;
      if (expected_q.size() == 0) begin
        report("result with no terminator waiting");
        return;
      end
      want = expected_q.pop_front();
      check_field("valid_res", 8'(got.valid_res), 8'(want.valid_res));
      check_field("id_kind", 8'(got.id_kind), 8'(want.id_kind));
      check_field("has_signature", 8'(got.has_signature), 8'(want.has_signature));
      check_field("option_count", got.option_count, want.option_count);
      check_field("total_len", got.total_len, want.total_len);
      check_field("local_len", got.local_len, want.local_len);
      check_field("domain_len", got.domain_len, want.domain_len);
      check_field("base_len", got.base_len, want.base_len);
      check_field("first_opt_start", got.first_opt_start, want.first_opt_start);
      check_field("first_opt_len", got.first_opt_len, want.first_opt_len);
      check_field("sig_len", got.sig_len, want.sig_len);
      n_results++;
      if (want.valid_res) n_valid++;
      if (want.has_signature) n_sig++;
      if (want.valid_res && want.id_kind == KIND_SERVICE) n_service++;
      if (want.valid_res && want.id_kind == KIND_DOMAIN) n_domain++;
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     char_valid = 1'b0;
  logic     char_stall;
  iap_in_t  char_item = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  iap_out_t res_item;

  iap_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;
  int sent_items  = 0;

  identity_address_parser_top uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  always #1 clk = ~clk;

  // Watch both channels and hand accepted items to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) sb.note_char(char_item);
      if (res_valid && !res_stall) sb.check_result(res_item);
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // End the run when neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (char_valid && !char_stall) || (res_valid && !res_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one character item, with random idle cycles ahead of it.
  task automatic send_char(logic [7:0] c, bit sel);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= '{char_byte: c, selector_mode: sel};
    do @(posedge clk); while (char_stall);
    sent_items++;
  endtask

  // Send a string and its terminator; only the first item's flag matters.
  task automatic send_string(logic [7:0] s[$], bit sel);
    foreach (s[i]) send_char(s[i], (i == 0) ? sel : bit'($urandom_range(1)));
    send_char(CH_NUL, (s.size() == 0) ? sel : bit'($urandom_range(1)));
  endtask

  task automatic send_text(string txt, bit sel);
    logic [7:0] s[$];
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    send_string(s, sel);
  endtask

  // Stop offering items and wait until every report has come back.
  task automatic wait_results();
    char_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] base_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E));
    while (c == CH_PLUS || c == CH_DOT || c == CH_AT);
    return c;
  endfunction

  // Localpart character: mostly base characters, now and then a dot.
  function automatic logic [7:0] local_char();
    return ($urandom_range(5) == 0) ? CH_DOT : base_char();
  endfunction

  // Well-formed identifier with random content: start, options, signature
  // flags and a dotted domain, with the extra forms a selector allows.
  function automatic void build_identity(ref logic [7:0] s[$], input bit sel);
    int  form, n_labels;
    bit  has_local, opts_ok;
    s.delete();
    form      = $urandom_range(3);
    has_local = 1;
    opts_ok   = 1;
    if (form == 0) begin
      has_local = 0;
      opts_ok   = 0;
    end else if (form == 1) begin
      s.push_back(CH_PLUS);
      if (sel && $urandom_range(1)) opts_ok = 1;
      else repeat ($urandom_range(1, 4)) s.push_back(local_char());
    end else begin
      repeat ($urandom_range(1, 5)) s.push_back(local_char());
    end
    if (opts_ok) begin
      repeat ($urandom_range(0, 3)) begin
        s.push_back(CH_PLUS);
        repeat ($urandom_range(0, 3)) s.push_back(local_char());
      end
      if (has_local && $urandom_range(2) == 0) begin
        s.push_back(CH_PLUS);
        repeat ($urandom_range(0, 2)) s.push_back(base_char());
        s.push_back(CH_PLUS);
      end
    end
    s.push_back(CH_AT);
    if (sel) repeat ($urandom_range(0, 2)) s.push_back(CH_DOT);
    n_labels = $urandom_range(1, 3);
    for (int k = 0; k < n_labels; k++) begin
      if (k != 0) begin
        s.push_back(CH_DOT);
        if (sel) repeat ($urandom_range(0, 1)) s.push_back(CH_DOT);
      end
      repeat ($urandom_range(1, 4)) s.push_back(base_char());
    end
    if (sel && $urandom_range(3) == 0) s.push_back(CH_DOT);
  endfunction

  // One random string: mostly well-formed, some corrupted or pure noise.
  task automatic send_random_string();
    logic [7:0] s[$];
    bit         sel;
    int         pick, k;
    sel  = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.delete();
      repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(1, 255)));
    end else begin
      build_identity(s, sel);
      if (pick < 22) begin
        k = $urandom_range(s.size() - 1);
        s[k] = 8'($urandom_range(1, 255));
      end else if (pick < 30) begin
        k = $urandom_range(s.size() - 1);
        s = s[0:k];
        s.pop_back();
      end
    end
    send_string(s, sel);
  endtask

  initial begin : stimulus
    logic [7:0] s[$];
    int         goal;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: empty, domain only, a selector ending on a dot,
    // signature flags, an unfinished string and bytes outside the base range.
    send_text("", 1'b0);
    send_text("@d", 1'b0);
    send_text("+@.", 1'b1);
    send_text("a+b++@d", 1'b0);
    send_text("+.", 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h7F, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(CH_NUL, 1'b1);
    wait_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 62; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 62; end
        default: begin tx_idle_pct = 31; rx_idle_pct = 31; end
      endcase
      goal = sent_items + PHASE_ITEMS;
      if (p == 0) begin
        // A well-formed identifier one character longer than the length
        // limit: every position up to the limit is parsed, the last one fails.
        s.delete();
        repeat (MAX_LEN_DEF - 2) s.push_back(base_char());
        s.push_back(CH_AT);
        s.push_back(base_char());
        s.push_back(base_char());
        send_string(s, 1'b0);
        goal = sent_items + PHASE_ITEMS;
      end
      // Back the parser up: the receiver holds while strings keep coming.
      if (p == 2) hold_left = HOLD_CYCLES;
      while (sent_items < goal) begin
        send_random_string();
        if (p == 1 && sent_items >= goal - PHASE_ITEMS / 2 && sb.pending() != 0)
          wait_results();
      end
      wait_results();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d characters; %0d reports checked, %0d valid (%0d service, %0d domain only)",
             sent_items, sb.n_results, sb.n_valid, sb.n_service, sb.n_domain);
    $display("Signature reports: %0d; mismatches: %0d", sb.n_sig, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/iap_pkg.sv
design/identity_address_parser_top.sv
tb/tb_identity_address_parser_top.sv
